>>> rtl/ppmc_pkg.sv
package ppmc_pkg;

  // Mode codes, as reported in the mode field of a result.
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_IDLE_SW = 4'd1;
  localparam logic [3:0] MODE_CV      = 4'd2;
  localparam logic [3:0] MODE_CV_SW   = 4'd3;
  localparam logic [3:0] MODE_CC      = 4'd4;
  localparam logic [3:0] MODE_CC_SW   = 4'd5;
  localparam logic [3:0] MODE_OVP     = 4'd6;
  localparam logic [3:0] MODE_OCP     = 4'd7;
  localparam logic [3:0] MODE_SCP     = 4'd8;
  localparam logic [3:0] MODE_OTP     = 4'd9;
  localparam logic [3:0] MODE_OPP     = 4'd10;
  localparam logic [3:0] MODE_LOCK    = 4'd11;

  // Event codes.
  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_SCP  = 4'd1;
  localparam logic [3:0] EV_OCP  = 4'd2;
  localparam logic [3:0] EV_OVP  = 4'd3;
  localparam logic [3:0] EV_OTP  = 4'd4;
  localparam logic [3:0] EV_OPP  = 4'd5;
  localparam logic [3:0] EV_CC   = 4'd6;
  localparam logic [3:0] EV_IDLE = 4'd7;
  localparam logic [3:0] EV_CV   = 4'd8;

  // Item kinds.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_FORCE  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SYSTEM_ENABLE     = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_SETPOINT  = 3'd1;
  localparam logic [2:0] REG_CURRENT_SETPOINT  = 3'd2;
  localparam logic [2:0] REG_POWER_LIMIT       = 3'd3;
  localparam logic [2:0] REG_TEMPERATURE_LIMIT = 3'd4;

  localparam logic [17:0]        POWER_LIMIT_RESET = 18'd160000;
  localparam logic signed [11:0] TEMP_LIMIT_RESET  = 12'sd600;

  typedef struct packed {
    logic               system_enable;
    logic [15:0]        voltage_setpoint;
    logic [15:0]        current_setpoint;
    logic [17:0]        power_limit;
    logic signed [11:0] temperature_limit;
  } ppmc_cfg_t;

  typedef struct packed {
    logic       tripped;
    logic [3:0] event_code;
    logic [3:0] mode;
  } ppmc_res_t;

endpackage

>>> rtl/power_protection_mode_controller.sv
// Protection and mode supervisor for a digital buck-boost supply. Each input
// transfer is one item: the kind (tuser) selects a sample check, a mode tick,
// a forced mode write or no operation, and every item yields exactly one
// result transfer carrying the trip flag, an event code and the mode after the
// item. The block takes one item per clock cycle while the result stream does
// not stall; a result passes through two register stages, the input register
// and then the result register. The mode register is read and written while
// an item sits between them, so the next item always sees the updated mode
// and the rate stays at one item per cycle.
// The registers (enable, voltage and current setpoints, power and temperature
// limits) sit on an APB-style port and should only be written while no item
// is in flight.
module power_protection_mode_controller
  import ppmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0: vout_sample[15:0], iout_sample[31:16], pout_sample[49:32],
  // temperature_sample[61:50], current_loop_active[62], forced_mode[66:63], zero fill.
  input  logic [71:0] s_axis_tdata,
  // tuser: action[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, from bit 0: tripped[0], event_code[4:1], mode[8:5], zero fill.
  output logic [15:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ppmc_cfg_t cfg;

  // Input register stage.
  logic               in_valid_q;
  logic [1:0]         action_q;
  logic [15:0]        vout_q;
  logic [15:0]        iout_q;
  logic [17:0]        pout_q;
  logic signed [11:0] temp_q;
  logic               loop_q;
  logic [3:0]         forced_q;

  // Result register stage.
  logic      out_valid_q;
  ppmc_res_t res_q;
  ppmc_res_t res;

  logic [3:0] fault;
  logic       advance;
  logic       step;

  // The whole pipe moves whenever the result register is free or being taken.
  // An empty input register may always be filled.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = advance || !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q <= s_axis_tuser;
      vout_q   <= s_axis_tdata[15:0];
      iout_q   <= s_axis_tdata[31:16];
      pout_q   <= s_axis_tdata[49:32];
      temp_q   <= $signed(s_axis_tdata[61:50]);
      loop_q   <= s_axis_tdata[62];
      forced_q <= s_axis_tdata[66:63];
    end
  end

  ppmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppmc_fault_check u_fault (
    .cfg_i   (cfg),
    .vout_i  (vout_q),
    .iout_i  (iout_q),
    .pout_i  (pout_q),
    .temp_i  (temp_q),
    .fault_o (fault)
  );

  ppmc_mode_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (action_q),
    .loop_active_i (loop_q),
    .forced_mode_i (forced_q),
    .fault_i       (fault),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.mode, res_q.event_code, res_q.tripped};

  a_trip_has_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.tripped ==
      ((res_q.event_code >= EV_SCP) && (res_q.event_code <= EV_OPP))))
    else $error("trip flag and event code disagree");

  a_stalled_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("an item in the input register was dropped during a stall");

  a_result_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.mode <= MODE_LOCK))
    else $error("result carries an undefined mode code");

endmodule

>>> rtl/ppmc_cfg_regs.sv
module ppmc_cfg_regs
  import ppmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output ppmc_cfg_t   cfg_o
);

  ppmc_cfg_t cfg_q;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.system_enable     <= 1'b0;
      cfg_q.voltage_setpoint  <= 16'd0;
      cfg_q.current_setpoint  <= 16'd0;
      cfg_q.power_limit       <= POWER_LIMIT_RESET;
      cfg_q.temperature_limit <= TEMP_LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SYSTEM_ENABLE:     cfg_q.system_enable     <= pwdata[0];
        REG_VOLTAGE_SETPOINT:  cfg_q.voltage_setpoint  <= pwdata[15:0];
        REG_CURRENT_SETPOINT:  cfg_q.current_setpoint  <= pwdata[15:0];
        REG_POWER_LIMIT:       cfg_q.power_limit       <= pwdata[17:0];
        REG_TEMPERATURE_LIMIT: cfg_q.temperature_limit <= $signed(pwdata[11:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SYSTEM_ENABLE:     prdata = {31'd0, cfg_q.system_enable};
      REG_VOLTAGE_SETPOINT:  prdata = {16'd0, cfg_q.voltage_setpoint};
      REG_CURRENT_SETPOINT:  prdata = {16'd0, cfg_q.current_setpoint};
      REG_POWER_LIMIT:       prdata = {14'd0, cfg_q.power_limit};
      REG_TEMPERATURE_LIMIT: prdata = {20'd0, cfg_q.temperature_limit};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/ppmc_fault_check.sv
module ppmc_fault_check
  import ppmc_pkg::*;
(
  input  ppmc_cfg_t          cfg_i,
  input  logic [15:0]        vout_i,
  input  logic [15:0]        iout_i,
  input  logic [17:0]        pout_i,
  input  logic signed [11:0] temp_i,
  output logic [3:0]         fault_o
);

  // Margins as exact integer compares on 20-bit products.
  logic [19:0] i_x10, v_x10, iset_x13, iset_x11, vset_x11, vset_x7;

  assign i_x10    = 20'(iout_i) * 20'd10;
  assign v_x10    = 20'(vout_i) * 20'd10;
  assign iset_x13 = 20'(cfg_i.current_setpoint) * 20'd13;
  assign iset_x11 = 20'(cfg_i.current_setpoint) * 20'd11;
  assign vset_x11 = 20'(cfg_i.voltage_setpoint) * 20'd11;
  assign vset_x7  = 20'(cfg_i.voltage_setpoint) * 20'd7;

  always_comb begin
    if (!cfg_i.system_enable) begin
      fault_o = EV_NONE;
    end else if ((i_x10 > iset_x13) && (v_x10 < vset_x7)) begin
      fault_o = EV_SCP;
    end else if (i_x10 > iset_x11) begin
      fault_o = EV_OCP;
    end else if (v_x10 > vset_x11) begin
      fault_o = EV_OVP;
    end else if (temp_i > cfg_i.temperature_limit) begin
      fault_o = EV_OTP;
    end else if (pout_i > cfg_i.power_limit) begin
      fault_o = EV_OPP;
    end else begin
      fault_o = EV_NONE;
    end
  end

endmodule

>>> rtl/ppmc_mode_fsm.sv
module ppmc_mode_fsm
  import ppmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] action_i,
  input  logic       loop_active_i,
  input  logic [3:0] forced_mode_i,
  input  logic [3:0] fault_i,
  output ppmc_res_t  res_o
);

  logic [3:0] mode_q, mode_d;
  logic       cc_allowed_q, cc_allowed_d;
  logic [3:0] ev;
  logic       trip;

  always_comb begin
    mode_d       = mode_q;
    cc_allowed_d = cc_allowed_q;
    ev           = EV_NONE;
    trip         = 1'b0;
    case (action_i)
      ACT_SAMPLE: begin
        ev   = fault_i;
        trip = (fault_i != EV_NONE);
        case (fault_i)
          EV_SCP:  mode_d = MODE_SCP;
          EV_OCP:  mode_d = MODE_OCP;
          EV_OVP:  mode_d = MODE_OVP;
          EV_OTP:  mode_d = MODE_OTP;
          EV_OPP:  mode_d = MODE_OPP;
          default: ;
        endcase
      end
      ACT_TICK: begin
        case (mode_q)
          MODE_CV: begin
            if (loop_active_i && cc_allowed_q) begin
              cc_allowed_d = 1'b0;
              mode_d       = MODE_CC_SW;
              ev           = EV_CC;
            end
          end
          MODE_CC: begin
            if (!cc_allowed_q && !loop_active_i) begin
              cc_allowed_d = 1'b1;
              mode_d       = MODE_CV_SW;
            end
          end
          MODE_IDLE_SW: begin
            cc_allowed_d = 1'b1;
            mode_d       = MODE_IDLE;
            ev           = EV_IDLE;
          end
          MODE_CC_SW: mode_d = MODE_CC;
          MODE_CV_SW: begin
            mode_d = MODE_CV;
            ev     = EV_CV;
          end
          MODE_OVP, MODE_OCP, MODE_SCP, MODE_OTP, MODE_OPP: mode_d = MODE_LOCK;
          default: ;
        endcase
      end
      ACT_FORCE: begin
        if (forced_mode_i <= MODE_LOCK) begin
          mode_d = forced_mode_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      cc_allowed_q <= 1'b1;
    end else if (step_i) begin
      mode_q       <= mode_d;
      cc_allowed_q <= cc_allowed_d;
    end
  end

  assign res_o.tripped    = trip;
  assign res_o.event_code = ev;
  assign res_o.mode       = mode_d;

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_LOCK)
    else $error("mode register holds an undefined code");

  a_trip_enters_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && trip |=> (mode_q >= MODE_OVP) && (mode_q <= MODE_OPP))
    else $error("a trip did not leave the machine in a fault mode");

  a_cc_entry_clears_allow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (ev == EV_CC) |=> !cc_allowed_q && (mode_q == MODE_CC_SW))
    else $error("entry to current regulation left the allow flag set");

endmodule

>>> dv/power_protection_mode_controller_tb.sv
module power_protection_mode_controller_tb
  import ppmc_pkg::*;
();

  // Input item as it sits in s_axis_tdata: vout lowest, forced_mode highest.
  typedef struct packed {
    logic [3:0]         forced_mode;
    logic               loop_active;
    logic signed [11:0] temp;
    logic [17:0]        pout;
    logic [15:0]        iout;
    logic [15:0]        vout;
  } ppmc_item_t;

  // Register index that lies beyond the register list; writes to it must do nothing.
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  // Tracks the supervisor's mode, its CC permission and its registers, works out the
  // result of every accepted item and checks results in order against those.
  class protection_predictor;
    ppmc_cfg_t   cfg;
    logic [3:0]  mode;
    logic        cc_allowed;
    ppmc_res_t   pending_results[$];
    int unsigned errors, results, trips;
    int unsigned n_sample, n_tick, n_force, n_nop;
    logic [8:0]  events_seen;
    logic [11:0] modes_seen;

    function new();
      cfg = '{system_enable: 1'b0, voltage_setpoint: 16'd0, current_setpoint: 16'd0,
              power_limit: POWER_LIMIT_RESET, temperature_limit: TEMP_LIMIT_RESET};
      mode        = MODE_IDLE;
      cc_allowed  = 1'b1;
      errors      = 0;
      results     = 0;
      trips       = 0;
      n_sample    = 0;
      n_tick      = 0;
      n_force     = 0;
      n_nop       = 0;
      events_seen = '0;
      modes_seen  = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SYSTEM_ENABLE:     cfg.system_enable     = val[0];
        REG_VOLTAGE_SETPOINT:  cfg.voltage_setpoint  = val[15:0];
        REG_CURRENT_SETPOINT:  cfg.current_setpoint  = val[15:0];
        REG_POWER_LIMIT:       cfg.power_limit       = val[17:0];
        REG_TEMPERATURE_LIMIT: cfg.temperature_limit = val[11:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] act, ppmc_item_t it);
      ppmc_res_t r;
      r.tripped    = 1'b0;
      r.event_code = EV_NONE;
      case (act)
        ACT_SAMPLE: begin
          n_sample++;
          // Faults in priority order; the first one found wins.
          if (cfg.system_enable) begin
            if (32'd10 * it.iout > 32'd13 * cfg.current_setpoint &&
                32'd10 * it.vout < 32'd7 * cfg.voltage_setpoint) begin
              r.event_code = EV_SCP;
              mode         = MODE_SCP;
            end else if (32'd10 * it.iout > 32'd11 * cfg.current_setpoint) begin
              r.event_code = EV_OCP;
              mode         = MODE_OCP;
            end else if (32'd10 * it.vout > 32'd11 * cfg.voltage_setpoint) begin
              r.event_code = EV_OVP;
              mode         = MODE_OVP;
            end else if ($signed(it.temp) > $signed(cfg.temperature_limit)) begin
              r.event_code = EV_OTP;
              mode         = MODE_OTP;
            end else if (it.pout > cfg.power_limit) begin
              r.event_code = EV_OPP;
              mode         = MODE_OPP;
            end
          end
          r.tripped = (r.event_code != EV_NONE);
        end
        ACT_TICK: begin
          n_tick++;
          case (mode)
            MODE_CV: begin
              if (it.loop_active && cc_allowed) begin
                cc_allowed   = 1'b0;
                mode         = MODE_CC_SW;
                r.event_code = EV_CC;
              end
            end
            MODE_CC: begin
              if (!cc_allowed && !it.loop_active) begin
                cc_allowed = 1'b1;
                mode       = MODE_CV_SW;
              end
            end
            MODE_IDLE_SW: begin
              cc_allowed   = 1'b1;
              mode         = MODE_IDLE;
              r.event_code = EV_IDLE;
            end
            MODE_CC_SW: mode = MODE_CC;
            MODE_CV_SW: begin
              mode         = MODE_CV;
              r.event_code = EV_CV;
            end
            MODE_OVP, MODE_OCP, MODE_SCP, MODE_OTP, MODE_OPP: mode = MODE_LOCK;
            default: ;
          endcase
        end
        ACT_FORCE: begin
          n_force++;
          if (it.forced_mode <= MODE_LOCK) mode = it.forced_mode;
        end
        default: n_nop++;
      endcase
      r.mode = mode;
      pending_results.push_back(r);
    endfunction

    function void flag(string what, ppmc_res_t want, ppmc_res_t got);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] error %0d, %s: want t=%0d e=%0d m=%0d, got t=%0d e=%0d m=%0d",
                 $time, errors, what, want.tripped, want.event_code, want.mode,
                 got.tripped, got.event_code, got.mode);
      end
    endfunction

    function void check_result(logic [15:0] data);
      ppmc_res_t got, want;
      got.tripped    = data[0];
      got.event_code = data[4:1];
      got.mode       = data[8:5];
      results++;
      if (got.tripped) trips++;
      if (got.event_code <= EV_CV) events_seen[got.event_code] = 1'b1;
      if (got.mode <= MODE_LOCK) modes_seen[got.mode] = 1'b1;
      if (pending_results.size() == 0) begin
        flag("result with nothing outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.tripped != want.tripped || got.event_code != want.event_code ||
            got.mode != want.mode) begin
          flag("result mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = ACT_NOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cfg_sets    = 0;

  protection_predictor pred;

  power_protection_mode_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls at random; the share of stalled cycles is set per phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Both streams are sampled at the clock edge, before anything driven at that edge
  // has settled. An input transfer is noted before a result of the same edge is
  // checked, which is safe as a result can never belong to a later item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pred.note_item(s_axis_tuser, ppmc_item_t'(s_axis_tdata[66:0]));
      end
      if (m_axis_tvalid && m_axis_tready) pred.check_result(m_axis_tdata);
    end
  end

  // Offers one item, with random gaps in front of it, and returns at the edge at
  // which the transfer takes place. tvalid is left high for a following item.
  task automatic send_item(input logic [1:0] act, input ppmc_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'd0, it};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [15:0] v,
                             input logic [15:0] i, input logic [17:0] p, input int t,
                             input logic loop, input logic [3:0] fm);
    ppmc_item_t it;
    it.vout        = v;
    it.iout        = i;
    it.pout        = p;
    it.temp        = 12'(t);
    it.loop_active = loop;
    it.forced_mode = fm;
    send_item(act, it);
  endtask

  // Mostly a value within a few counts of a trip threshold, sometimes anything.
  function automatic int near_value(input int centre, input int top);
    int val;
    if ($urandom_range(3) == 0) return int'($urandom_range(top));
    val = centre + int'($urandom_range(6)) - 3;
    if (val < 0) val = 0;
    if (val > top) val = top;
    return val;
  endfunction

  task automatic send_random();
    ppmc_item_t  it;
    logic [1:0]  act;
    int unsigned pick, vs, cs;
    pick = $urandom_range(99);
    act  = (pick < 40) ? ACT_SAMPLE : (pick < 75) ? ACT_TICK :
           (pick < 94) ? ACT_FORCE : ACT_NOP;
    vs   = pred.cfg.voltage_setpoint;
    cs   = pred.cfg.current_setpoint;
    // Aim voltage and current at the short-circuit and over-limit margins.
    case ($urandom_range(2))
      0:       it.vout = 16'(near_value(int'(vs * 7 / 10), 65535));
      1:       it.vout = 16'(near_value(int'(vs * 11 / 10), 65535));
      default: it.vout = 16'(near_value(int'(vs), 65535));
    endcase
    case ($urandom_range(2))
      0:       it.iout = 16'(near_value(int'(cs * 13 / 10), 65535));
      1:       it.iout = 16'(near_value(int'(cs * 11 / 10), 65535));
      default: it.iout = 16'(near_value(int'(cs * 9 / 10), 65535));
    endcase
    it.pout = 18'(near_value(int'(pred.cfg.power_limit), 262143));
    it.temp = 12'(near_value(int'($signed(pred.cfg.temperature_limit)) + 512, 2559) - 512);
    it.loop_active = 1'($urandom_range(1));
    // Mode writes favour the regulating modes so that ticks walk the CV/CC cycle.
    case ($urandom_range(9))
      0, 1, 2, 3: it.forced_mode = MODE_CV;
      4, 5:       it.forced_mode = MODE_CC;
      6:          it.forced_mode = MODE_IDLE_SW;
      default:    it.forced_mode = 4'($urandom_range(15));
    endcase
    send_item(act, it);
  endtask

  // A register write: setup cycle, then access cycle until pready is seen.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pred.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [15:0] v, input logic [15:0] i,
                            input logic [17:0] p, input int t);
    reg_write(REG_SYSTEM_ENABLE, {31'd0, en});
    reg_write(REG_VOLTAGE_SETPOINT, {16'd0, v});
    reg_write(REG_CURRENT_SETPOINT, {16'd0, i});
    reg_write(REG_POWER_LIMIT, {14'd0, p});
    reg_write(REG_TEMPERATURE_LIMIT, 32'(t));
    cfg_sets++;
  endtask

  // Holds the sender off until every outstanding result has come back. The first
  // edge lets the monitor note the last transfer before the count is looked at.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pred.pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    pred = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Protection is off after reset, so even gross overloads must not trip.
    send_fields(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 2047, 1'b1, 4'hF);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    send_fields(ACT_NOP, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    wait_for_results();

    // Enable with 10 V and 4 A; the power and temperature limits keep their reset
    // values. A write to an unmapped index must leave everything alone.
    reg_write(REG_SYSTEM_ENABLE, 32'd1);
    reg_write(REG_VOLTAGE_SETPOINT, 32'd10000);
    reg_write(REG_CURRENT_SETPOINT, 32'd4000);
    reg_write(REG_UNMAPPED, 32'd0);
    cfg_sets++;

    send_fields(ACT_SAMPLE, 16'd10000, 16'd3000, 18'd1000, 250, 1'b0, MODE_IDLE);
    // Short circuit: current past 1.3x with voltage below 0.7x.
    send_fields(ACT_SAMPLE, 16'd6000, 16'd5300, 18'd1000, 250, 1'b0, MODE_IDLE);
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_CV);
    send_fields(ACT_SAMPLE, 16'd10000, 16'd4500, 18'd1000, 250, 1'b0, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    // A fault still overrides the latched lock.
    send_fields(ACT_SAMPLE, 16'd11001, 16'd4000, 18'd1000, 250, 1'b0, MODE_IDLE);
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_CV);
    // Every quantity exactly at its limit: nothing trips.
    send_fields(ACT_SAMPLE, 16'd11000, 16'd4400, 18'd160000, 600, 1'b0, MODE_IDLE);
    send_fields(ACT_SAMPLE, 16'd10000, 16'd4000, 18'd1000, 601, 1'b0, MODE_IDLE);
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_CV);
    send_fields(ACT_SAMPLE, 16'd10000, 16'd4000, 18'd160001, 0, 1'b0, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    // The full CV to CC and back cycle.
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_CV);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE_SW);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b0, MODE_IDLE);
    send_fields(ACT_TICK, 16'd0, 16'd0, 18'd0, 0, 1'b1, MODE_IDLE);
    // Mode codes past the lock are ignored.
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, 4'd12);
    send_fields(ACT_FORCE, 16'd0, 16'd0, 18'd0, 0, 1'b0, 4'd15);
    send_fields(ACT_NOP, 16'hFFFF, 16'hFFFF, 18'h3FFFF, -1, 1'b1, 4'hF);
    send_fields(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 2047, 1'b1, 4'hF);
    send_fields(ACT_SAMPLE, 16'd0, 16'd0, 18'd0, -512, 1'b0, 4'd0);
    wait_for_results();

    // Six random phases, each under its own register setting; pairs of phases share an idling pattern.
    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 71 : 0;
      rx_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 12 : 0;
      case (phase)
        0: set_config(1'b1, 16'd12000, 16'd5000, 18'd100000, 600);
        1: set_config(1'b1, 16'd0, 16'd0, 18'd0, -512);
        2: set_config(1'b1, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 2047);
        3: set_config(1'b0, 16'($urandom), 16'($urandom), 18'($urandom), 450);
        4: set_config(1'b1, 16'($urandom), 16'($urandom), 18'($urandom),
                      int'($urandom_range(2559)) - 512);
        default: set_config(1'b1, 16'd3300, 16'd2000, 18'd6600, 450);
      endcase
      repeat (125) send_random();
      wait_for_results();
    end

    repeat (10) @(posedge clk_i);
    while (pred.pending_results.size() != 0) begin
      pred.flag("result never arrived", pred.pending_results.pop_front(), '0);
    end

    $display("Covered %0d samples, %0d ticks, %0d mode writes, %0d no-ops, %0d settings.",
             pred.n_sample, pred.n_tick, pred.n_force, pred.n_nop, cfg_sets);
    $display("Checked %0d results with %0d trips; events seen %b, modes seen %b.",
             pred.results, pred.trips, pred.events_seen, pred.modes_seen);
    if (pred.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
